/* hw/rtl/assert_macros.svh */
// assertion helpers for the low-pass filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cfl_pkg.sv */
package cfl_pkg;

  // sample, coefficient and state widths
  localparam int COEF_W = 24;
  localparam int DELAY_W = 40;
  localparam int FRAC_BITS = 23;
  // delay words are multiplied in two halves
  localparam int HALF_W = DELAY_W / 2;
  localparam int PART_W = HALF_W + 1;
  localparam int PROD_W = COEF_W + PART_W;
  localparam int ACC_W = 64;
  localparam int ASR_W = ACC_W - FRAC_BITS;
  localparam int SUM_W = ASR_W + 1;

  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 2'd2;

  localparam logic signed [DELAY_W-1:0] DELAY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
  localparam logic signed [DELAY_W-1:0] DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] OUT_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] OUT_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // one-hot sequencer states: idle plus one per step of a section
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_A_LO  = 9'b000000010,
    S_A_HI  = 9'b000000100,
    S_B1_LO = 9'b000001000,
    S_B1_HI = 9'b000010000,
    S_B0_LO = 9'b000100000,
    S_B0_HI = 9'b001000000,
    S_Y_ACC = 9'b010000000,
    S_Y_OUT = 9'b100000000
  } state_t;

  // accumulator control from the sequencer
  typedef struct packed {
    logic load;
    logic add;
  } mac_ctl_t;

  // clamp a sum to the 40-bit delay range
  function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [SUM_W-1:0] v);
    logic signed [DELAY_W-1:0] r;
    if (v > SUM_W'(DELAY_MAX)) begin
      r = DELAY_MAX;
    end else if (v < SUM_W'(DELAY_MIN)) begin
      r = DELAY_MIN;
    end else begin
      r = v[DELAY_W-1:0];
    end
    return r;
  endfunction

  // clamp a sum to the 24-bit sample range
  function automatic logic signed [COEF_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [COEF_W-1:0] r;
    if (v > SUM_W'(OUT_MAX)) begin
      r = OUT_MAX;
    end else if (v < SUM_W'(OUT_MIN)) begin
      r = OUT_MIN;
    end else begin
      r = v[COEF_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/cfl_mac.sv */
module cfl_mac (
  input  logic                                clk,
  input  logic signed [cfl_pkg::COEF_W-1:0]   coef,
  input  logic signed [cfl_pkg::PART_W-1:0]   part,
  input  cfl_pkg::mac_ctl_t                   ctl,
  output logic signed [cfl_pkg::ASR_W-1:0]    acc_asr
);

  logic signed [cfl_pkg::PROD_W-1:0] prod;
  logic signed [cfl_pkg::ACC_W-1:0]  acc;

  // partial product, registered before accumulation
  always_ff @(posedge clk) begin
    prod <= coef * part;
  end

  // low half loads, high half adds in shifted by the half width
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= cfl_pkg::ACC_W'(prod);
    end else if (ctl.add) begin
      acc <= acc + (cfl_pkg::ACC_W'(prod) <<< cfl_pkg::HALF_W);
    end
  end

  // arithmetic shift right drops the fraction bits
  assign acc_asr = acc[cfl_pkg::ACC_W-1:cfl_pkg::FRAC_BITS];

endmodule

/* hw/rtl/cascaded_first_order_lowpass.sv */
// Two cascaded first-order IIR low-pass sections on signed Q1.23 samples.
// Input channel: in_valid/in_ready with sample_in; a transaction is taken
// when both are high. Output channel: out_valid/out_ready with sample_out.
// Coefficients b0, b1, a1 are written through cfg_we/cfg_index/cfg_data
// (index 0, 1, 2; index 3 is ignored). The user must write them only while
// the filter is idle; the block itself does not enforce it. All products
// go through one 24x21 multiplier with a 64-bit accumulator; each 24x40
// product takes two passes (low and high half of the delay). A section
// steps through a1*d, b1*d, b0*w, then the output sum. in_ready is high
// only while the sequencer is idle, so a new sample is taken only after
// the previous one has run through both sections.
// The result sits in an output register, so a new sample is taken while
// the previous result waits; if the receiver still stalls when the next
// result is done, the sequencer holds in its last step until it drains.
// Reset (rst, synchronous) clears coefficients, both delay words, the
// sequencer and out_valid.
`include "assert_macros.svh"

module cascaded_first_order_lowpass (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cfl_pkg::COEF_W-1:0]   sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cfl_pkg::COEF_W-1:0]   sample_out,
  input  logic                                cfg_we,
  input  logic [cfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cfl_pkg::COEF_W-1:0]          cfg_data
);

  cfl_pkg::state_t state, state_next;
  logic sec;

  logic signed [cfl_pkg::COEF_W-1:0]  coef_b0, coef_b1, coef_a1;
  logic signed [cfl_pkg::DELAY_W-1:0] d1, d2;
  logic signed [cfl_pkg::DELAY_W-1:0] x;
  logic signed [cfl_pkg::ASR_W-1:0]   ysum;

  logic signed [cfl_pkg::DELAY_W-1:0] dsel;
  logic signed [cfl_pkg::COEF_W-1:0]  mul_coef;
  logic signed [cfl_pkg::PART_W-1:0]  mul_part;
  cfl_pkg::mac_ctl_t                  mac_ctl;
  logic signed [cfl_pkg::ASR_W-1:0]   acc_asr;

  logic signed [cfl_pkg::SUM_W-1:0]   w_sum, y_sum;
  logic in_fire, finish;

  assign in_ready = (state == cfl_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign finish   = (state == cfl_pkg::S_Y_OUT) && sec && (!out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_a1 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfl_pkg::REG_B0: coef_b0 <= cfg_data;
        cfl_pkg::REG_B1: coef_b1 <= cfg_data;
        cfl_pkg::REG_A1: coef_a1 <= cfg_data;
        default: ;
      endcase
    end
  end

  // delay word of the active section
  assign dsel = sec ? d2 : d1;

  // multiplier operand and accumulator control per step
  always_comb begin
    mul_coef = coef_b0;
    mul_part = $signed({1'b0, dsel[cfl_pkg::HALF_W-1:0]});
    mac_ctl  = '0;
    unique case (state)
      cfl_pkg::S_A_LO: begin
        mul_coef = coef_a1;
      end
      cfl_pkg::S_A_HI: begin
        mul_coef = coef_a1;
        mul_part = $signed({dsel[cfl_pkg::DELAY_W-1], dsel[cfl_pkg::DELAY_W-1:cfl_pkg::HALF_W]});
        mac_ctl.load = 1'b1;
      end
      cfl_pkg::S_B1_LO: begin
        mul_coef = coef_b1;
        mac_ctl.add = 1'b1;
      end
      cfl_pkg::S_B1_HI: begin
        mul_coef = coef_b1;
        mul_part = $signed({dsel[cfl_pkg::DELAY_W-1], dsel[cfl_pkg::DELAY_W-1:cfl_pkg::HALF_W]});
        mac_ctl.load = 1'b1;
      end
      cfl_pkg::S_B0_LO: begin
        mac_ctl.add = 1'b1;
      end
      cfl_pkg::S_B0_HI: begin
        mul_part = $signed({dsel[cfl_pkg::DELAY_W-1], dsel[cfl_pkg::DELAY_W-1:cfl_pkg::HALF_W]});
        mac_ctl.load = 1'b1;
      end
      cfl_pkg::S_Y_ACC: begin
        mac_ctl.add = 1'b1;
      end
      cfl_pkg::S_IDLE, cfl_pkg::S_Y_OUT: ;
      default: ;
    endcase
  end

  cfl_mac u_mac (
    .clk     (clk),
    .coef    (mul_coef),
    .part    (mul_part),
    .ctl     (mac_ctl),
    .acc_asr (acc_asr)
  );

  // w = x - (a1*d >> 23), y = (b1*d >> 23) + (b0*w >> 23)
  assign w_sum = cfl_pkg::SUM_W'(x) - cfl_pkg::SUM_W'(acc_asr);
  assign y_sum = cfl_pkg::SUM_W'(ysum) + cfl_pkg::SUM_W'(acc_asr);

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      cfl_pkg::S_IDLE:  if (in_fire) state_next = cfl_pkg::S_A_LO;
      cfl_pkg::S_A_LO:  state_next = cfl_pkg::S_A_HI;
      cfl_pkg::S_A_HI:  state_next = cfl_pkg::S_B1_LO;
      cfl_pkg::S_B1_LO: state_next = cfl_pkg::S_B1_HI;
      cfl_pkg::S_B1_HI: state_next = cfl_pkg::S_B0_LO;
      cfl_pkg::S_B0_LO: state_next = cfl_pkg::S_B0_HI;
      cfl_pkg::S_B0_HI: state_next = cfl_pkg::S_Y_ACC;
      cfl_pkg::S_Y_ACC: state_next = cfl_pkg::S_Y_OUT;
      cfl_pkg::S_Y_OUT: begin
        if (!sec) begin
          state_next = cfl_pkg::S_A_LO;
        end else if (finish) begin
          state_next = cfl_pkg::S_IDLE;
        end
      end
      default: state_next = cfl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfl_pkg::S_IDLE;
      sec   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        sec <= 1'b0;
      end else if (state == cfl_pkg::S_Y_OUT && !sec) begin
        sec <= 1'b1;
      end
    end
  end

  // section input: the sample, then the clamped first-section output
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x <= cfl_pkg::DELAY_W'(sample_in);
    end else if (state == cfl_pkg::S_Y_OUT && !sec) begin
      x <= cfl_pkg::sat_delay(y_sum);
    end
  end

  // b1 term held while b0*w runs
  always_ff @(posedge clk) begin
    if (state == cfl_pkg::S_B0_HI) begin
      ysum <= acc_asr;
    end
  end

  // delay update: w replaces d once b1*d has read the old value
  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
    end else if (state == cfl_pkg::S_B1_HI) begin
      if (sec) begin
        d2 <= cfl_pkg::sat_delay(w_sum);
      end else begin
        d1 <= cfl_pkg::sat_delay(w_sum);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      sample_out <= cfl_pkg::sat_out(y_sum);
    end
  end

  // checks
  `ASSERT_CLK(a_fixed_latency, in_valid && in_ready |-> ##16 (state == cfl_pkg::S_Y_OUT && sec), "sample did not reach the last step in 16 cycles")
  `ASSERT_CLK(a_result_source, $rose(out_valid) |-> $past(state == cfl_pkg::S_Y_OUT && sec), "out_valid rose outside the final step")
  `ASSERT_ALWAYS(a_reset_clear, rst |=> (d1 == '0 && d2 == '0 && !out_valid && in_ready), "reset left state behind")

endmodule

/* sim/cascaded_first_order_lowpass_tb.sv */
module cascaded_first_order_lowpass_tb;
  import cfl_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS = 40;
  // one index past the last coefficient, writes there must not land anywhere
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RAMP_ITEMS = 320;

  typedef struct {
    logic signed [COEF_W-1:0] sample;
    int gap;
  } sample_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COEF_W-1:0] sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COEF_W-1:0] sample_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // predictor state: coefficients and both delay words
  longint signed coef_b0_m = 0;
  longint signed coef_b1_m = 0;
  longint signed coef_a1_m = 0;
  longint signed delay1_m = 0;
  longint signed delay2_m = 0;

  sample_req_t pending_samples[$];
  logic signed [COEF_W-1:0] expected_samples[$];
  sample_req_t tx_req;
  logic signed [COEF_W-1:0] exp_sample;
  int gap_left = 0;
  int n_queued = 0;
  int n_taken = 0;
  int n_fail = 0;
  int cycle_count = 0;
  logic in_fire = 1'b0;

  // receiver knobs
  logic rx_random = 1'b0;
  logic hold_trig = 1'b0;
  logic hold_seen = 1'b0;
  int hold_len = 0;
  int hold_left = 0;
  int stall_left = 0;

  cascaded_first_order_lowpass uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint signed clamp64(input longint signed v, input longint signed lo,
                                            input longint signed hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one direct-form-ii section, returns y and the new delay word
  function automatic longint signed lp_section(input longint signed x, input longint signed d,
                                               output longint signed w);
    longint signed y;
    w = clamp64(x - ((coef_a1_m * d) >>> FRAC_BITS), longint'(DELAY_MIN), longint'(DELAY_MAX));
    y = ((coef_b0_m * w) >>> FRAC_BITS) + ((coef_b1_m * d) >>> FRAC_BITS);
    return y;
  endfunction

  // both sections in cascade, updates the predictor delays
  function automatic logic signed [COEF_W-1:0] filter_sample(input logic signed [COEF_W-1:0] x);
    longint signed y1, y2, w1, w2;
    y1 = clamp64(lp_section(longint'(x), delay1_m, w1), longint'(DELAY_MIN), longint'(DELAY_MAX));
    y2 = clamp64(lp_section(y1, delay2_m, w2), longint'(OUT_MIN), longint'(OUT_MAX));
    delay1_m = w1;
    delay2_m = w2;
    return y2[COEF_W-1:0];
  endfunction

  // mostly short gaps, a few long ones
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [COEF_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return OUT_MAX;
      1: return OUT_MIN;
      2: return '0;
      3, 4: return COEF_W'($urandom_range(0, 511)) - COEF_W'(256);
      default: return COEF_W'($urandom());
    endcase
  endfunction

  task automatic queue_sample(input logic signed [COEF_W-1:0] s, input int gap);
    sample_req_t r;
    r.sample = s;
    r.gap = gap;
    pending_samples.push_back(r);
    n_queued++;
  endtask

  // coefficient write, only issued while the filter is drained
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_B0: coef_b0_m = longint'($signed(val));
      REG_B1: coef_b1_m = longint'($signed(val));
      REG_A1: coef_a1_m = longint'($signed(val));
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                           input logic [COEF_W-1:0] a1);
    write_coef(REG_B0, b0);
    write_coef(REG_B1, b1);
    write_coef(REG_A1, a1);
  endtask

  task automatic wait_drained();
    while (n_taken != n_queued || expected_samples.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // sender: one transaction per queued sample, gap after each
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_samples.size() != 0) begin
        tx_req = pending_samples.pop_front();
        sample_in <= tx_req.sample;
        in_valid <= 1'b1;
        gap_left <= tx_req.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: long hold-off on request, otherwise random or no stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_seen <= hold_trig;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_random && $urandom_range(0, 3) == 0) begin
      stall_left <= rand_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: check results in order, predict each accepted sample
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          if (n_fail < MAX_REPORTS)
            $error("sample_out: transaction with none expected, actual %0d", sample_out);
          n_fail++;
        end else begin
          exp_sample = expected_samples.pop_front();
          if (sample_out !== exp_sample) begin
            if (n_fail < MAX_REPORTS)
              $error("sample_out: expected %0d, actual %0d", exp_sample, sample_out);
            n_fail++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_samples.push_back(filter_sample(sample_in));
        n_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int i;
    int k;
    logic [COEF_W-1:0] b0, b1, a1;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // coefficients at reset value, output stays zero
    queue_sample(0, 0);
    queue_sample(OUT_MAX, 1);
    queue_sample(OUT_MIN, 0);
    queue_sample(1, 2);
    queue_sample(-1, 0);
    wait_drained();

    // full-scale gains, final output clamps both ways; spare index is ignored
    write_all(OUT_MAX, OUT_MAX, '0);
    write_coef(REG_SPARE, OUT_MIN);
    rx_random <= 1'b1;
    for (i = 0; i < 3; i++) queue_sample(OUT_MAX, rand_gap());
    for (i = 0; i < 3; i++) queue_sample(OUT_MIN, rand_gap());
    for (i = 0; i < 4; i++) queue_sample(i[0] ? OUT_MIN : OUT_MAX, 0);
    queue_sample(0, 0);
    wait_drained();

    // typical smoothing setting
    write_all(24'h080000, 24'h080000, 24'h900000);
    for (i = 0; i < 6; i++) queue_sample(i < 3 ? OUT_MAX : 24'sd0, rand_gap());
    wait_drained();

    // integrator ramp: second delay word grows quadratically into saturation
    rx_random <= 1'b0;
    write_all(OUT_MIN, OUT_MIN, OUT_MIN);
    for (i = 0; i < RAMP_ITEMS; i++) queue_sample(OUT_MIN, 0);
    wait_drained();

    // random phases
    for (k = 0; k < 8; k++) begin
      case (k)
        0: begin b0 = OUT_MAX; b1 = OUT_MAX; a1 = OUT_MAX; end
        1: begin b0 = OUT_MIN; b1 = OUT_MIN; a1 = OUT_MIN; end
        2: begin b0 = 24'h080000; b1 = 24'h080000; a1 = 24'h900000; end
        3: begin b0 = '0; b1 = '0; a1 = rand_value(); end
        default: begin b0 = rand_value(); b1 = rand_value(); a1 = rand_value(); end
      endcase
      write_all(b0, b1, a1);
      if (k >= 4) write_coef(REG_SPARE, rand_value());
      rx_random <= (k % 3 != 0);
      if (k == 2) begin
        // receiver holds off while samples keep coming, input backs up
        hold_len = 400;
        hold_trig <= ~hold_trig;
        for (i = 0; i < 12; i++) queue_sample(rand_value(), 0);
      end
      for (i = 0; i < 190; i++) queue_sample(rand_value(), (k % 3 == 1) ? 0 : rand_gap());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (n_fail == 0 && expected_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
